/* design/pn3d_pkg.sv */
// Shared types, constants and a helper function for the 3D gradient noise unit.
// Used by pn3d_core, perlin_noise_3d_unit and the port checker.
package pn3d_pkg;

  localparam int unsigned TableDepthDefault   = 512;
  localparam int unsigned FractionBitsDefault = 16;
  localparam int unsigned CoordWidth          = 24;
  localparam int unsigned ValueWidth          = 8;
  localparam int unsigned NoiseWidth          = 18;
  localparam int unsigned Q16One              = 65536;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_EVAL = 1'b1
  } opcode_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FADE_FF,
    ST_FADE_C1,
    ST_FADE_C2,
    ST_FADE_P,
    ST_FADE_W,
    ST_RD_A,
    ST_WT_A,
    ST_RD_B,
    ST_WT_B,
    ST_RD_C,
    ST_WT_C,
    ST_LERP,
    ST_LERP_W,
    ST_DONE
  } state_e;

  // Gradient applied to one corner offset, per the sixteen hash cases.
  function automatic logic signed [18:0] grad(input logic [3:0] h,
                                              input logic signed [17:0] x,
                                              input logic signed [17:0] y,
                                              input logic signed [17:0] z);
    logic signed [18:0] xs, ys, zs, r;
    xs = {x[17], x};
    ys = {y[17], y};
    zs = {z[17], z};
    unique case (h)
      4'd0:    r =  xs + ys;
      4'd1:    r = -xs + ys;
      4'd2:    r =  xs - ys;
      4'd3:    r = -xs - ys;
      4'd4:    r =  xs + zs;
      4'd5:    r = -xs + zs;
      4'd6:    r =  xs - zs;
      4'd7:    r = -xs - zs;
      4'd8:    r =  ys + zs;
      4'd9:    r = -ys + zs;
      4'd10:   r =  ys - zs;
      4'd11:   r = -ys - zs;
      4'd12:   r =  ys + xs;
      4'd13:   r = -ys + zs;
      4'd14:   r =  ys - xs;
      default: r = -ys - zs;
    endcase
    return r;
  endfunction

endpackage

/* design/pn3d_core.sv */
// Sequencer, shared multiplier and permutation memory of the 3D gradient noise unit.
// Depends on pn3d_pkg.
module pn3d_core #(
  parameter int unsigned TableDepth   = pn3d_pkg::TableDepthDefault,
  parameter int unsigned FractionBits = pn3d_pkg::FractionBitsDefault
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   start_i,
  input  pn3d_pkg::opcode_e                      opcode_i,
  input  logic [pn3d_pkg::CoordWidth-1:0]        coord_x_i,
  input  logic [pn3d_pkg::CoordWidth-1:0]        coord_y_i,
  input  logic [pn3d_pkg::CoordWidth-1:0]        coord_z_i,
  input  logic [$clog2(TableDepth)-1:0]          entry_index_i,
  input  logic [pn3d_pkg::ValueWidth-1:0]        entry_value_i,
  output logic                                   busy_o,
  output logic                                   done_o,
  output logic signed [pn3d_pkg::NoiseWidth-1:0] noise_o
);
  import pn3d_pkg::*;

  localparam int unsigned IdxW = $clog2(TableDepth);

  // Permutation memory, one port, registered read.
  logic [ValueWidth-1:0] mem_q [TableDepth];
  logic [ValueWidth-1:0] rd_q;
  logic                  mem_we;
  logic                  mem_re;
  logic [IdxW-1:0]       mem_addr;

  // The read register holds its byte through the wait cycle that follows a read.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_addr] <= entry_value_i;
    end
    if (mem_re) begin
      rd_q <= mem_q[mem_addr];
    end
  end

  state_e state_q, state_d;

  logic [7:0]  cx_q, cy_q, cz_q;
  logic [15:0] f_q [3];
  logic [15:0] w_q [3];
  logic [1:0]  ax_q;
  logic [2:0]  cn_q;
  logic signed [18:0] v_q [8];
  logic [2:0]  ln_q;
  logic [33:0] t_q;
  logic [33:0] c_q;

  // Shared multiplier: 35 x 18 signed.
  logic signed [34:0] mul_a;
  logic signed [17:0] mul_b;
  logic signed [52:0] mul_p_q;
  logic signed [52:0] mul_p;
  assign mul_p = mul_a * mul_b;

  function automatic logic [15:0] frac16(input logic [CoordWidth-1:0] c);
    logic [FractionBits-1:0] f;
    logic [39:0] e;
    f = c[FractionBits-1:0];
    e = {{(40-FractionBits){1'b0}}, f};
    if (FractionBits >= 16) begin
      return 16'(e >> (FractionBits - 16));
    end
    return 16'(e << (16 - FractionBits));
  endfunction

  logic [15:0] fcur;
  logic [1:0]  lerp_wsel;
  logic signed [18:0] la, lb;
  assign fcur = f_q[ax_q];

  // Lerp order: x pairs 0..3, then y pairs, then z.
  always_comb begin
    unique case (ln_q)
      3'd0: begin la = v_q[0]; lb = v_q[4]; end
      3'd1: begin la = v_q[2]; lb = v_q[6]; end
      3'd2: begin la = v_q[1]; lb = v_q[5]; end
      3'd3: begin la = v_q[3]; lb = v_q[7]; end
      3'd4: begin la = v_q[0]; lb = v_q[2]; end
      3'd5: begin la = v_q[1]; lb = v_q[3]; end
      default: begin la = v_q[0]; lb = v_q[1]; end
    endcase
    lerp_wsel = (ln_q < 3'd4) ? 2'd0 : ((ln_q < 3'd6) ? 2'd1 : 2'd2);
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:    if (start_i && opcode_i == OP_EVAL) state_d = ST_FADE_FF;
      ST_FADE_FF: state_d = ST_FADE_C1;
      ST_FADE_C1: state_d = ST_FADE_C2;
      ST_FADE_C2: state_d = ST_FADE_P;
      ST_FADE_P:  state_d = ST_FADE_W;
      ST_FADE_W:  state_d = (ax_q == 2'd2) ? ST_RD_A : ST_FADE_FF;
      ST_RD_A:    state_d = ST_WT_A;
      ST_WT_A:    state_d = ST_RD_B;
      ST_RD_B:    state_d = ST_WT_B;
      ST_WT_B:    state_d = ST_RD_C;
      ST_RD_C:    state_d = ST_WT_C;
      ST_WT_C:    state_d = (cn_q == 3'd7) ? ST_LERP : ST_RD_A;
      ST_LERP:    state_d = ST_LERP_W;
      ST_LERP_W:  state_d = (ln_q == 3'd6) ? ST_DONE : ST_LERP;
      ST_DONE:    state_d = ST_IDLE;
      default:    state_d = ST_IDLE;
    endcase
  end

  // Outputs of the sequencer: memory port and multiplier operands.
  always_comb begin
    mem_we   = 1'b0;
    mem_re   = 1'b0;
    mem_addr = entry_index_i;
    mul_a    = '0;
    mul_b    = '0;
    unique case (state_q)
      ST_IDLE: mem_we = start_i && opcode_i == OP_LOAD;
      ST_FADE_FF: begin
        mul_a = 35'(fcur);
        mul_b = 18'(fcur);
      end
      ST_FADE_C1: begin
        mul_a = 35'(mul_p_q[47:16]);
        mul_b = 18'(fcur);
      end
      ST_FADE_C2: begin
        mul_a = 35'(fcur);
        mul_b = 18'(fcur);
      end
      ST_FADE_P: begin
        // The polynomial term needs up to 20 bits, so it takes the wide operand.
        mul_a = 35'(t_q);
        mul_b = 18'(c_q);
      end
      ST_RD_A: begin
        mem_re   = 1'b1;
        mem_addr = IdxW'({1'b0, cx_q} + 9'(cn_q[2]));
      end
      ST_RD_B: begin
        mem_re   = 1'b1;
        mem_addr = IdxW'({1'b0, rd_q} + {1'b0, cy_q} + 9'(cn_q[1]));
      end
      ST_RD_C: begin
        mem_re   = 1'b1;
        mem_addr = IdxW'({1'b0, rd_q} + {1'b0, cz_q} + 9'(cn_q[0]));
      end
      ST_LERP: begin
        mul_a = 35'(lb) - 35'(la);
        mul_b = 18'(w_q[lerp_wsel]);
      end
      default: ;
    endcase
  end

  logic [35:0] p_poly;
  always_comb begin
    // (6f^2 - 15*2^16 f + 10*2^32) >> 16 from f^2 held in mul_p_q.
    p_poly = 36'((6 * {2'b0, mul_p_q[33:0]} + (36'd10 << 32)
              - 36'd15 * {4'b0, fcur, 16'b0}) >> 16);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      ax_q    <= '0;
      cn_q    <= '0;
      ln_q    <= '0;
    end else begin
      state_q <= state_d;
      unique case (state_q)
        ST_IDLE:   begin ax_q <= '0; cn_q <= '0; ln_q <= '0; end
        ST_FADE_W: ax_q <= ax_q + 2'd1;
        ST_WT_C:   cn_q <= cn_q + 3'd1;
        ST_LERP_W: ln_q <= ln_q + 3'd1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    mul_p_q <= mul_p;
    unique case (state_q)
      ST_IDLE: if (start_i) begin
        cx_q <= 8'(coord_x_i >> FractionBits);
        cy_q <= 8'(coord_y_i >> FractionBits);
        cz_q <= 8'(coord_z_i >> FractionBits);
        f_q[0] <= frac16(coord_x_i);
        f_q[1] <= frac16(coord_y_i);
        f_q[2] <= frac16(coord_z_i);
      end
      ST_FADE_C2: c_q <= 34'(mul_p_q[47:16]);
      ST_FADE_P:  t_q <= '0;
      ST_FADE_W:  w_q[ax_q] <= mul_p_q[31:16];
      ST_WT_C: v_q[cn_q] <= grad(rd_q[3:0],
          18'($signed({2'b0, f_q[0]}) - (cn_q[2] ? 18'sd65536 : 18'sd0)),
          18'($signed({2'b0, f_q[1]}) - (cn_q[1] ? 18'sd65536 : 18'sd0)),
          18'($signed({2'b0, f_q[2]}) - (cn_q[0] ? 18'sd65536 : 18'sd0)));
      ST_LERP_W: begin
        unique case (ln_q)
          3'd0, 3'd4, 3'd6: v_q[ln_q == 3'd0 ? 0 : (ln_q == 3'd4 ? 0 : 0)]
                            <= la + 19'(mul_p_q >>> 16);
          3'd1: v_q[2] <= la + 19'(mul_p_q >>> 16);
          3'd2: v_q[1] <= la + 19'(mul_p_q >>> 16);
          3'd3: v_q[3] <= la + 19'(mul_p_q >>> 16);
          default: v_q[1] <= la + 19'(mul_p_q >>> 16);
        endcase
      end
      default: ;
    endcase
    // The polynomial term is formed from f squared on the fade pass.
    if (state_q == ST_FADE_C1) t_q <= 34'(p_poly);
  end

  assign busy_o  = state_q != ST_IDLE;
  assign done_o  = state_q == ST_DONE;
  assign noise_o = v_q[0][NoiseWidth-1:0];

endmodule

/* design/perlin_noise_3d_unit.sv */
// Top level of the 3D gradient noise unit: handshakes and output register.
// Depends on pn3d_pkg and pn3d_core.
//
// One input channel (valid_i / stall_o) carries load and evaluate items; one output
// channel (valid_o / stall_i) carries noise results. A load writes one byte of the
// permutation memory in the cycle it is transferred and yields no result.
// An evaluate item runs the three fade polynomials on the shared multiplier (five
// steps per axis), then the eight corners with three dependent reads of the
// single-port memory each (a read step and a wait step per read), then the seven
// blends; a final step fills the output register. The input is stalled while an
// item is at work. The result sits in an output register; a load is accepted while
// it waits, but an evaluate is stalled until the register has drained, so a finished
// result is never overwritten. A new evaluate is thus taken only after the last one
// has finished and its result has left the output register.
// Reset clears control state; the memory content is undefined until loaded.
module perlin_noise_3d_unit #(
  parameter int unsigned TableDepth   = pn3d_pkg::TableDepthDefault,
  parameter int unsigned FractionBits = pn3d_pkg::FractionBitsDefault
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   valid_i,
  output logic                                   stall_o,
  input  logic                                   opcode_i,
  input  logic [pn3d_pkg::CoordWidth-1:0]        coord_x_i,
  input  logic [pn3d_pkg::CoordWidth-1:0]        coord_y_i,
  input  logic [pn3d_pkg::CoordWidth-1:0]        coord_z_i,
  input  logic [$clog2(TableDepth)-1:0]          entry_index_i,
  input  logic [pn3d_pkg::ValueWidth-1:0]        entry_value_i,
  output logic                                   valid_o,
  input  logic                                   stall_i,
  output logic signed [pn3d_pkg::NoiseWidth-1:0] noise_value_o
);
  import pn3d_pkg::*;

  logic busy, done, full_q;
  logic signed [NoiseWidth-1:0] noise, out_q;

  // An evaluate waits for the output register to drain first.
  assign stall_o = busy || (full_q && opcode_i == OP_EVAL);

  pn3d_core #(
    .TableDepth  (TableDepth),
    .FractionBits(FractionBits)
  ) u_core (
    .clk_i,
    .rst_ni,
    .start_i      (valid_i && !stall_o),
    .opcode_i     (opcode_e'(opcode_i)),
    .coord_x_i,
    .coord_y_i,
    .coord_z_i,
    .entry_index_i,
    .entry_value_i,
    .busy_o       (busy),
    .done_o       (done),
    .noise_o      (noise)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      full_q <= 1'b0;
    end else if (done) begin
      full_q <= 1'b1;
    end else if (!stall_i) begin
      full_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (done) begin
      out_q <= noise;
    end
  end

  assign valid_o       = full_q;
  assign noise_value_o = out_q;

endmodule

/* design/pn3d_checker.sv */
// Port-level checker for the 3D gradient noise unit, bound to the top level.
// Depends on pn3d_pkg.
module pn3d_checker (
  input logic                                   clk_i,
  input logic                                   rst_ni,
  input logic                                   valid_i,
  input logic                                   stall_o,
  input logic                                   opcode_i,
  input logic                                   valid_o,
  input logic                                   stall_i,
  input logic signed [pn3d_pkg::NoiseWidth-1:0] noise_value_o
);
  import pn3d_pkg::*;

  // A waiting result holds its value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && stall_i |=> valid_o && $stable(noise_value_o))
    else $error("result changed while stalled");

  // A transferred evaluate keeps the input stalled in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && !stall_o && opcode_i == OP_EVAL |=> stall_o)
    else $error("input not stalled during evaluation");

  // A load produces no result by itself.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !valid_o && valid_i && !stall_o && opcode_i == OP_LOAD |=> !valid_o)
    else $error("load produced a result");

endmodule

bind perlin_noise_3d_unit pn3d_checker u_pn3d_checker (.*);

/* bench/tb_top.sv */
// Self-checking bench for perlin_noise_3d_unit: table loads and noise evaluations
// are driven with random gaps and back-pressure; each result is checked against an
// in-bench noise predictor or a fixed value. Depends on pn3d_pkg and the unit's RTL.
module tb_top;
  import pn3d_pkg::*;

  localparam int unsigned FracBits    = FractionBitsDefault;
  localparam int unsigned Depth       = TableDepthDefault;
  localparam int unsigned IdxW        = $clog2(Depth);
  localparam int          RandomItems = 1420;
  localparam int          HoldCycles  = 400;

  typedef struct {
    opcode_e               op;
    logic [CoordWidth-1:0] x, y, z;
    logic [IdxW-1:0]       idx;
    logic [ValueWidth-1:0] val;
    bit                    fixed;
    logic signed [17:0]    noise;
  } row_t;

  logic                         clk_i = 1'b0;
  logic                         rst_ni = 1'b0;
  logic                         valid_i = 1'b0;
  logic                         stall_o;
  logic                         opcode_i = OP_LOAD;
  logic [CoordWidth-1:0]        coord_x_i = '0;
  logic [CoordWidth-1:0]        coord_y_i = '0;
  logic [CoordWidth-1:0]        coord_z_i = '0;
  logic [IdxW-1:0]              entry_index_i = '0;
  logic [ValueWidth-1:0]        entry_value_i = '0;
  logic                         valid_o;
  logic                         stall_i = 1'b1;
  logic signed [NoiseWidth-1:0] noise_value_o;

  logic [7:0]         perm_copy [Depth];
  logic signed [17:0] pending_noise [$];
  int                 errors = 0;
  int                 evals_sent = 0;
  int                 loads_sent = 0;
  int                 results_seen = 0;
  bit                 hold_request = 1'b0;
  bit                 sender_quiet = 1'b0;

  perlin_noise_3d_unit u_top (.*);

  always #5 clk_i = ~clk_i;

  function automatic longint fade_q16(longint unsigned f);
    longint unsigned p, c;
    p = 6 * f * f + (64'd10 << 32) - 15 * 64'd65536 * f;
    p = p >> 16;
    c = (((f * f) >> 16) * f) >> 16;
    return longint'((c * p) >> 16);
  endfunction

  function automatic longint blend(longint a, longint b, longint w);
    return a + (((b - a) * w) >>> 16);
  endfunction

  function automatic longint corner_grad(logic [3:0] h, longint x, longint y, longint z);
    case (h)
      4'd0:    return  x + y;
      4'd1:    return -x + y;
      4'd2:    return  x - y;
      4'd3:    return -x - y;
      4'd4:    return  x + z;
      4'd5:    return -x + z;
      4'd6:    return  x - z;
      4'd7:    return -x - z;
      4'd8:    return  y + z;
      4'd9:    return -y + z;
      4'd10:   return  y - z;
      4'd11:   return -y - z;
      4'd12:   return  y + x;
      4'd13:   return -y + z;
      4'd14:   return  y - x;
      default: return -y - z;
    endcase
  endfunction

  function automatic longint frac_of(logic [CoordWidth-1:0] c);
    longint unsigned f;
    f = c & ((64'd1 << FracBits) - 1);
    if (FracBits >= 16) return longint'(f >> (FracBits - 16));
    return longint'(f << (16 - FracBits));
  endfunction

  function automatic logic signed [17:0] predict_noise(logic [CoordWidth-1:0] x,
                                                       logic [CoordWidth-1:0] y,
                                                       logic [CoordWidth-1:0] z);
    int unsigned cx, cy, cz, a, b, h;
    longint fx, fy, fz, wx, wy, wz, x0, x1, x2, x3, y0, y1;
    longint v [2][2][2];
    cx = (x >> FracBits) & 255;
    cy = (y >> FracBits) & 255;
    cz = (z >> FracBits) & 255;
    fx = frac_of(x);
    fy = frac_of(y);
    fz = frac_of(z);
    wx = fade_q16(fx);
    wy = fade_q16(fy);
    wz = fade_q16(fz);
    for (int i = 0; i < 2; i++)
      for (int j = 0; j < 2; j++)
        for (int k = 0; k < 2; k++) begin
          a = perm_copy[(cx + i) % Depth];
          b = perm_copy[(a + cy + j) % Depth];
          h = perm_copy[(b + cz + k) % Depth];
          v[i][j][k] = corner_grad(h[3:0], fx - i * Q16One, fy - j * Q16One,
                                   fz - k * Q16One);
        end
    x0 = blend(v[0][0][0], v[1][0][0], wx);
    x1 = blend(v[0][1][0], v[1][1][0], wx);
    x2 = blend(v[0][0][1], v[1][0][1], wx);
    x3 = blend(v[0][1][1], v[1][1][1], wx);
    y0 = blend(x0, x1, wy);
    y1 = blend(x2, x3, wy);
    return 18'(blend(y0, y1, wz));
  endfunction

  task automatic report_mismatch(string what);
    errors++;
    $display("ERROR @%0t: %s", $time, what);
  endtask

  // One item is offered after a random gap (none when quiet) and held until its transfer.
  task automatic offer_item(row_t r);
    int gap;
    gap = sender_quiet ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    valid_i       <= 1'b1;
    opcode_i      <= r.op;
    coord_x_i     <= r.x;
    coord_y_i     <= r.y;
    coord_z_i     <= r.z;
    entry_index_i <= r.idx;
    entry_value_i <= r.val;
    @(posedge clk_i);
    while (stall_o) @(posedge clk_i);
    if (r.op == OP_LOAD) begin
      perm_copy[r.idx] = r.val;
      loads_sent++;
    end else begin
      pending_noise.push_back(r.fixed ? r.noise : predict_noise(r.x, r.y, r.z));
      evals_sent++;
    end
  endtask

  function automatic logic [CoordWidth-1:0] rand_coord();
    logic [CoordWidth-1:0] c;
    c = CoordWidth'($urandom);
    case ($urandom_range(0, 9))
      0: c[15:0] = 16'h0000;
      1: c[15:0] = 16'hFFFF;
      2: c[23:16] = 8'hFF;
      default: ;
    endcase
    return c;
  endfunction

  function automatic row_t mk(opcode_e op, int x, int y, int z, int idx, int val,
                              bit fixed = 1'b0, int noise = 0);
    row_t r;
    r.op = op;
    r.x = CoordWidth'(x);
    r.y = CoordWidth'(y);
    r.z = CoordWidth'(z);
    r.idx = IdxW'(idx);
    r.val = ValueWidth'(val);
    r.fixed = fixed;
    r.noise = 18'(noise);
    return r;
  endfunction

  // Receiver: random stall before most results, plus one long hold-off on request.
  initial begin
    int n;
    @(posedge rst_ni);
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        stall_i <= 1'b1;
        repeat (HoldCycles) @(posedge clk_i);
      end
      n = (results_seen % 300 < 60) ? 0 : $urandom_range(0, 14);
      if (n > 0) begin
        stall_i <= 1'b1;
        repeat (n) @(posedge clk_i);
      end
      stall_i <= 1'b0;
      @(posedge clk_i);
      while (!valid_o) @(posedge clk_i);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && valid_o && !stall_i) begin
      results_seen++;
      if (pending_noise.size() == 0)
        report_mismatch($sformatf("unexpected noise result %0d", noise_value_o));
      else if (noise_value_o !== pending_noise[0]) begin
        report_mismatch($sformatf("noise_value got %0d want %0d",
                                  noise_value_o, pending_noise[0]));
        void'(pending_noise.pop_front());
      end else
        void'(pending_noise.pop_front());
    end
  end

  initial begin
    #20_000_000;
    $display("perlin_noise_3d_unit: mismatch");
    $finish;
  end

  initial begin
    row_t directed [$];
    row_t r;
    int   wait_cycles;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Every entry is written before the first evaluation reads the table.
    for (int i = 0; i < Depth; i++)
      offer_item(mk(OP_LOAD, 0, 0, 0, i, $urandom_range(0, 255)));

    // Integer points have zero offsets and zero fade weights, so the result is zero.
    directed.push_back(mk(OP_EVAL, 0, 0, 0, 0, 0, 1'b1, 0));
    directed.push_back(mk(OP_EVAL, 24'hFF0000, 24'hFF0000, 24'hFF0000, 0, 0, 1'b1, 0));
    directed.push_back(mk(OP_EVAL, 24'h010000, 0, 24'hFF0000, 511, 255, 1'b1, 0));
    directed.push_back(mk(OP_EVAL, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 0, 0));
    directed.push_back(mk(OP_EVAL, 24'h000001, 24'h000001, 24'h000001, 0, 0));
    directed.push_back(mk(OP_EVAL, 24'h008000, 24'h008000, 24'h008000, 0, 0));
    directed.push_back(mk(OP_EVAL, 24'h00FFFF, 0, 24'h7F8000, 0, 0));
    directed.push_back(mk(OP_LOAD, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 0, 0));
    directed.push_back(mk(OP_LOAD, 0, 0, 0, 511, 255));
    directed.push_back(mk(OP_LOAD, 0, 0, 0, 255, 255));
    directed.push_back(mk(OP_LOAD, 0, 0, 0, 256, 0));
    directed.push_back(mk(OP_EVAL, 24'hFFFFFF, 24'h00FFFF, 24'hFF0001, 0, 0));
    directed.push_back(mk(OP_EVAL, 24'hFF8000, 24'hFF8000, 24'hFF8000, 0, 0));
    directed.push_back(mk(OP_EVAL, 24'h000000, 24'hFFFFFF, 24'h000000, 0, 0));
    for (int h = 0; h < 4; h++)
      directed.push_back(mk(OP_EVAL, 24'h123456 + h, 24'h00C000, 24'hABCDEF, 0, 0));
    foreach (directed[i]) offer_item(directed[i]);

    for (int n = 0; n < RandomItems; n++) begin
      sender_quiet = (n % 400) >= 320;
      if (n == 700) hold_request = 1'b1;
      if ($urandom_range(0, 4) == 0)
        r = mk(OP_LOAD, rand_coord(), rand_coord(), rand_coord(),
               $urandom_range(0, Depth - 1), $urandom_range(0, 255));
      else
        r = mk(OP_EVAL, rand_coord(), rand_coord(), rand_coord(),
               $urandom_range(0, Depth - 1), $urandom_range(0, 255));
      offer_item(r);
    end
    valid_i <= 1'b0;

    wait_cycles = 0;
    while (pending_noise.size() != 0 && wait_cycles < 100_000) begin
      @(posedge clk_i);
      wait_cycles++;
    end
    repeat (60) @(posedge clk_i);

    $display("Ran %0d table loads and %0d noise evaluations, %0d results checked.",
             loads_sent, evals_sent, results_seen);
    $display("Random gaps and stalls on both sides, one long output hold-off.");
    if (errors == 0 && pending_noise.size() == 0) begin
      $display("perlin_noise_3d_unit: match");
    end else begin
      if (pending_noise.size() != 0)
        $display("ERROR: %0d results never arrived", pending_noise.size());
      $display("perlin_noise_3d_unit: mismatch");
    end
    $finish;
  end
endmodule

/* filelist.f */
design/pn3d_pkg.sv
design/pn3d_core.sv
design/perlin_noise_3d_unit.sv
design/pn3d_checker.sv
bench/tb_top.sv
